>>> hw/rtl/rcn_pkg.sv
// rcn_pkg: beat types, widths and the per-cell data word of the chromaticity
// normalizer. Used by rcn_front, rcn_cell and rgb_chromaticity_normalizer.
// No dependencies.
package rcn_pkg;

  // channel and share widths
  localparam int unsigned ChanW  = 8;
  localparam int unsigned ShareW = 8;
  // channel sum fits 3 * 255 = 765
  localparam int unsigned SumW   = 10;
  // 255 * channel fits 65025
  localparam int unsigned NumW   = 16;
  // widest shifted divisor: sum << (ShareW - 1)
  localparam int unsigned DivW   = SumW + ShareW;
  // one cell per quotient bit
  localparam int unsigned NumCells = ShareW;

  // input beat
  typedef struct packed {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
  } pix_t;

  // output beat
  typedef struct packed {
    logic [ShareW-1:0] blue_share;
    logic [ShareW-1:0] green_share;
    logic [ShareW-1:0] red_share;
    logic              black_pixel;
  } share_t;

  // partial remainder and quotient of one channel
  typedef struct packed {
    logic [NumW-1:0]   rem;
    logic [ShareW-1:0] quo;
  } chan_div_t;

  // word handed from cell to cell
  typedef struct packed {
    chan_div_t       blue;
    chan_div_t       green;
    chan_div_t       red;
    logic [SumW-1:0] sum;
    logic            black;
  } cell_data_t;

endpackage

>>> hw/rtl/rcn_front.sv
// rcn_front: entry register of the chain; forms the channel sum, the scaled
// numerators 255 * c and the black pixel flag. Depends on rcn_pkg.
module rcn_front import rcn_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  pix_t       data_i,
  output logic       stall_o,
  output logic       valid_o,
  output cell_data_t data_o,
  input  logic       stall_i
);

  logic       valid_q;
  cell_data_t data_q, data_d;

  // 255 * c as (c << 8) - c
  function automatic logic [NumW-1:0] scale255(input logic [ChanW-1:0] c);
    scale255 = {c, 8'd0} - {8'd0, c};
  endfunction

  // setup of the division word
  always_comb begin
    data_d           = '0;
    data_d.sum       = SumW'(data_i.blue) + SumW'(data_i.green) + SumW'(data_i.red);
    data_d.black     = (data_d.sum == '0);
    data_d.blue.rem  = scale255(data_i.blue);
    data_d.green.rem = scale255(data_i.green);
    data_d.red.rem   = scale255(data_i.red);
  end

  // hold while the next cell holds
  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> hw/rtl/rcn_cell.sv
// rcn_cell: one restoring division step for all three channels, resolving a
// single quotient bit, then registered. Depends on rcn_pkg.
module rcn_cell import rcn_pkg::*; #(
  parameter int unsigned Shift = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  cell_data_t data_i,
  output logic       stall_o,
  output logic       valid_o,
  output cell_data_t data_o,
  input  logic       stall_i
);

  logic       valid_q;
  cell_data_t data_q, data_d;
  logic [DivW-1:0] div;

  // one compare and subtract; black pixels never set a bit
  function automatic chan_div_t step(input chan_div_t cur, input logic [DivW-1:0] d,
                                     input logic blk);
    logic [DivW-1:0] r;
    logic            take;
    r    = DivW'(cur.rem);
    take = (r >= d) && !blk;
    step.rem = take ? NumW'(r - d) : cur.rem;
    step.quo = {cur.quo[ShareW-2:0], take};
  endfunction

  assign div = DivW'(data_i.sum) << Shift;

  always_comb begin
    data_d       = data_i;
    data_d.blue  = step(data_i.blue, div, data_i.black);
    data_d.green = step(data_i.green, div, data_i.black);
    data_d.red   = step(data_i.red, div, data_i.black);
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> hw/rtl/rgb_chromaticity_normalizer.sv
// rgb_chromaticity_normalizer: top level; front register and a chain of
// division cells, one per share bit. Depends on rcn_pkg, rcn_front, rcn_cell.
//
//   channel  dir  payload   handshake
//   in       in   pix_t     in_valid_i / in_stall_o
//   out      out  share_t   out_valid_o / out_stall_i
//
// one pixel per cycle sustained while out_stall_i is low; the path runs through
// the front register, then one cell per quotient bit of the 8-bit share
// each cell resolves one quotient bit of all three channels by compare/subtract
// reset clears the valid bit of every stage; data registers are not reset
// an output stall freezes only the full stages behind it; bubbles still close up
module rgb_chromaticity_normalizer import rcn_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  input  pix_t   in_data_i,
  output logic   in_stall_o,
  output logic   out_valid_o,
  output share_t out_data_o,
  input  logic   out_stall_i
);

  logic       valid [NumCells+1];
  logic       stall [NumCells+1];
  cell_data_t data  [NumCells+1];

  // entry stage
  rcn_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .stall_o (in_stall_o),
    .valid_o (valid[0]),
    .data_o  (data[0]),
    .stall_i (stall[0])
  );

  // chain of division cells, most significant bit first
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    rcn_cell #(
      .Shift (NumCells - 1 - k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[k]),
      .data_i  (data[k]),
      .stall_o (stall[k]),
      .valid_o (valid[k+1]),
      .data_o  (data[k+1]),
      .stall_i (stall[k+1])
    );
  end

  assign stall[NumCells] = out_stall_i;

  // output beat straight from the last cell register
  assign out_valid_o              = valid[NumCells];
  assign out_data_o.blue_share    = data[NumCells].blue.quo;
  assign out_data_o.green_share   = data[NumCells].green.quo;
  assign out_data_o.red_share     = data[NumCells].red.quo;
  assign out_data_o.black_pixel   = data[NumCells].black;

  // a stall at the input only comes from a held output beat
  a_stall_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held output beat");

  // black pixels give zero shares
  a_black_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.black_pixel) |->
      (out_data_o.blue_share == '0 && out_data_o.green_share == '0 &&
       out_data_o.red_share == '0))
    else $error("black pixel with nonzero share");

  // floored shares never add up past full scale
  a_share_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((SumW'(out_data_o.blue_share) + SumW'(out_data_o.green_share) +
                      SumW'(out_data_o.red_share)) <= SumW'(255)))
    else $error("shares exceed full scale");

  // the largest channel holds at least a third of full scale
  a_share_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.black_pixel) |->
      (out_data_o.blue_share >= ShareW'(85) || out_data_o.green_share >= ShareW'(85) ||
       out_data_o.red_share >= ShareW'(85)))
    else $error("no share reaches one third");

endmodule
